// ===== hdl/pfu_pkg.sv =====
// ----------------------------------------------------------------------------
// pfu_pkg
// Types and codes shared by the forwarding and hazard unit.
// ----------------------------------------------------------------------------
package pfu_pkg;

    localparam int SRC_W   = 5;
    localparam int STAGE_N = 5;

    localparam int ST_FETCH  = 0;
    localparam int ST_DECODE = 1;
    localparam int ST_EXEC   = 2;
    localparam int ST_MEM    = 3;
    localparam int ST_WB     = 4;

    localparam logic [STAGE_N-1:0] STAGE_EMPTY_RST = 5'b11110;

    typedef enum logic [1:0] {
        KIND_TWO  = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_NONE = 2'd2,
        KIND_RSVD = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        WB_LOAD = 2'd0,
        WB_ALU  = 2'd1,
        WB_PC4  = 2'd2,
        WB_NONE = 2'd3
    } wb_src_t;

    typedef enum logic [2:0] {
        FWD_REG      = 3'd0,
        FWD_WB       = 3'd1,
        FWD_MEM_LOAD = 3'd2,
        FWD_MEM_ALU  = 3'd3,
        FWD_MEM_PC4  = 3'd4,
        FWD_EXE_ALU  = 3'd5,
        FWD_EXE_PC4  = 3'd6
    } fwd_sel_t;

    // producer view of execute, memory and writeback
    typedef struct packed {
        logic [SRC_W-1:0] exec_dest;
        wb_src_t          exec_src;
        logic             exec_live;
        logic [SRC_W-1:0] mem_dest;
        wb_src_t          mem_src;
        logic             mem_live;
        logic [SRC_W-1:0] wb_dest;
        logic             wb_live;
    } pfu_prod_t;

endpackage

// ===== hdl/pipeline_hazard_forward_unit.sv =====
// ----------------------------------------------------------------------------
// pipeline_hazard_forward_unit
// Forwarding selects, load-use stall, redirect flush and bubble tracking.
// ----------------------------------------------------------------------------
// Each input word is held in the input register, and its result word is then captured in the output register.
// Throughput: 1 word per cycle unless m_axis_tready stalls; input register -> select logic -> output reg.
// Output register backpressure propagates combinationally to s_axis_tready.
// Reset: bubble bits go to 5'b11110 (all but fetch empty), both regs empty.
module pipeline_hazard_forward_unit #(
    parameter int REG_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // decode_src_a, decode_src_b, exec_dest, exec_wb_source, mem_dest,
    // mem_wb_source, wb_dest, wb_writes, redirect, zero pad
    input  logic [31:0] s_axis_tdata,
    // decode_kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // forward_a, forward_b, stall_front, flush_front, stage_empty_next,
    // retired, zero pad
    output logic [15:0] m_axis_tdata
);
    import pfu_pkg::*;

    logic                in_valid_reg;
    logic [31:0]         in_data_reg;
    kind_t               in_kind_reg;
    logic                out_valid_reg;
    logic [15:0]         out_data_reg;
    logic [STAGE_N-1:0]  empty_reg;
    logic [STAGE_N-1:0]  empty_next;

    logic                advance;
    logic                out_free;
    pfu_prod_t           prod;
    fwd_sel_t            sel_a;
    fwd_sel_t            sel_b;
    logic                haz_a;
    logic                haz_b;
    logic                use_a;
    logic                use_b;
    logic                stall;
    logic                flush;
    logic                retired;
    logic [STAGE_N-1:0]  empty_fl;
    logic [15:0]         out_data_next;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign prod.exec_dest = in_data_reg[14:10];
    assign prod.exec_src  = wb_src_t'(in_data_reg[16:15]);
    assign prod.exec_live = !empty_reg[ST_EXEC];
    assign prod.mem_dest  = in_data_reg[21:17];
    assign prod.mem_src   = wb_src_t'(in_data_reg[23:22]);
    assign prod.mem_live  = !empty_reg[ST_MEM];
    assign prod.wb_dest   = in_data_reg[28:24];
    assign prod.wb_live   = !empty_reg[ST_WB] && in_data_reg[29];

    assign use_a = in_kind_reg inside {KIND_TWO, KIND_ONE};
    assign use_b = (in_kind_reg == KIND_TWO);

    pfu_fwd_sel #(.REG_COUNT(REG_COUNT)) u_sel_a (
        .en     (use_a),
        .src    (in_data_reg[4:0]),
        .prod   (prod),
        .sel    (sel_a),
        .hazard (haz_a)
    );

    pfu_fwd_sel #(.REG_COUNT(REG_COUNT)) u_sel_b (
        .en     (use_b),
        .src    (in_data_reg[9:5]),
        .prod   (prod),
        .sel    (sel_b),
        .hazard (haz_b)
    );

    assign stall    = haz_a || haz_b;
    assign flush    = in_data_reg[30] && !empty_reg[ST_EXEC];
    assign retired  = !empty_reg[ST_WB];
    assign empty_fl = flush ? (empty_reg | 5'b00011) : empty_reg;

    always_comb
    begin
        if (stall)
        begin
            empty_next = {empty_fl[ST_MEM], empty_fl[ST_EXEC], 1'b1,
                          empty_fl[ST_DECODE], empty_fl[ST_FETCH]};
        end
        else
        begin
            empty_next = {empty_fl[3:0], 1'b0};
        end
    end

    assign out_data_next = {2'b00, retired, empty_next, flush, stall, sel_b, sel_a};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            empty_reg     <= STAGE_EMPTY_RST;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance;
            end
            if (advance)
            begin
                empty_reg <= empty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_kind_reg <= kind_t'(s_axis_tuser);
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== hdl/pfu_fwd_sel.sv =====
// ----------------------------------------------------------------------------
// pfu_fwd_sel
// Forwarding select and load-use detect for one source operand.
// ----------------------------------------------------------------------------
module pfu_fwd_sel #(
    parameter int REG_COUNT = 32
) (
    input  logic                     en,
    input  logic [pfu_pkg::SRC_W-1:0] src,
    input  pfu_pkg::pfu_prod_t       prod,
    output pfu_pkg::fwd_sel_t        sel,
    output logic                     hazard
);
    import pfu_pkg::*;

    logic usable;

    assign usable = en && (src != '0) && (int'(src) < REG_COUNT);

    always_comb
    begin
        sel    = FWD_REG;
        hazard = 1'b0;
        if (prod.wb_live && prod.wb_dest == src)
        begin
            sel = FWD_WB;
        end
        if (prod.mem_live && prod.mem_dest == src)
        begin
            case (prod.mem_src)
                WB_LOAD: sel = FWD_MEM_LOAD;
                WB_ALU:  sel = FWD_MEM_ALU;
                WB_PC4:  sel = FWD_MEM_PC4;
                default: sel = sel;
            endcase
        end
        if (prod.exec_live && prod.exec_dest == src)
        begin
            case (prod.exec_src)
                WB_LOAD: hazard = 1'b1;
                WB_ALU:  sel = FWD_EXE_ALU;
                WB_PC4:  sel = FWD_EXE_PC4;
                default: sel = sel;
            endcase
        end
        if (!usable)
        begin
            sel    = FWD_REG;
            hazard = 1'b0;
        end
    end

endmodule

// ===== hdl/pfu_checker.sv =====
// ----------------------------------------------------------------------------
// pfu_checker
// Port-level checks on the result stream of the hazard unit.
// ----------------------------------------------------------------------------
module pfu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // flush leaves decode empty
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[9])
        else $error("flush without decode bubble");

    // stall inserts an execute bubble
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[10])
        else $error("stall without execute bubble");

    // normal advance refills fetch
    a_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[6] && !m_axis_tdata[7] |-> !m_axis_tdata[8])
        else $error("fetch empty after plain advance");

    // no unused select codes
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7 && m_axis_tdata[5:3] != 3'd7)
        else $error("illegal forward select");

endmodule

bind pipeline_hazard_forward_unit pfu_checker u_pfu_checker (.*);
